/* rtl/tmc_pkg.sv */
// tcp mss clamp engine package: sizes, codes, payload structs and the
// one's complement update helper; no dependencies
`timescale 1ns / 1ps

package tmc_pkg;

    // packet buffer and counter sizes
    localparam int BUFFER_WORDS  = 32;
    localparam int ADDR_W        = $clog2(BUFFER_WORDS);
    localparam int MAX_PKT_WORDS = 30;
    localparam int CNT_W         = 6;
    localparam int N_W           = $clog2(MAX_PKT_WORDS + 2);
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // header constants
    localparam logic [15:0] HDR_MIN      = 16'd40;
    localparam logic [15:0] MSS_KIND_LEN = 16'h0204;
    localparam logic [15:0] DOFF_INC     = 16'h1000;
    localparam logic [7:0]  PROTO_TCP    = 8'd6;
    localparam logic [7:0]  OPT_MSS      = 8'd2;
    localparam logic [7:0]  OPT_MSS_LEN  = 8'd4;
    localparam logic [7:0]  OPT_NOP      = 8'd1;
    localparam logic [3:0]  DOFF_MIN     = 4'd5;
    localparam logic [3:0]  DOFF_MAX     = 4'd15;

    typedef enum logic [2:0] {
        ST_NOT_ELIG,
        ST_CLAMPED,
        ST_KEPT,
        ST_INSERTED,
        ST_BAD_LEN,
        ST_BAD_MTU,
        ST_NO_ROOM,
        ST_TOO_LONG
    } status_t;

    typedef enum logic [1:0] {
        CFG_CLAMP_MODE,
        CFG_FIXED_MSS,
        CFG_ROUTE_MTU,
        CFG_SRC_MTU
    } cfg_idx_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_RD_W0,
        BK_RD_W2,
        BK_RD_FLAGS,
        BK_RD_CK,
        BK_DECIDE,
        BK_WALK_A,
        BK_WALK_B,
        BK_WALK_C,
        BK_MISS,
        BK_CKSUM,
        BK_EMIT,
        BK_FLUSH
    } back_state_t;

    typedef struct packed {
        logic [31:0] packet_word;
        logic        last_word;
        logic        is_forward;
        logic        is_reverse;
    } in_t;

    typedef struct packed {
        logic [31:0] out_word;
        logic        out_last;
        status_t     status;
    } out_t;

    typedef struct packed {
        logic        clamp_mode;
        logic [15:0] fixed_mss;
        logic [15:0] route_mtu;
        logic [15:0] source_path_mtu;
    } cfg_t;

    typedef struct packed {
        logic [CNT_W-1:0] n;
        logic             fwd;
        logic             rev;
    } desc_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [31:0]       data;
    } mem_wr_t;

    // incremental one's complement checksum update, old value to new value
    function automatic logic [15:0] csum_fix(input logic [15:0] check,
                                             input logic [15:0] from_v,
                                             input logic [15:0] to_v);
        logic [17:0] s;
        logic [16:0] t;
        logic [16:0] u;
        s = {2'b00, ~check} + {2'b00, ~from_v} + {2'b00, to_v};
        t = {1'b0, s[15:0]} + {15'd0, s[17:16]};
        u = {1'b0, t[15:0]} + {16'd0, t[16]};
        return ~u[15:0];
    endfunction

endpackage

/* rtl/tcp_mss_clamp_engine_unit.sv */
// top level of the tcp mss clamp engine: configuration registers, front
// part and back part; uses tmc_pkg, tmc_front and tmc_back
`timescale 1ns / 1ps

// Packet words are taken one a cycle while busy is low; the beat with
// last_word set closes the packet. busy then stays high while the back
// part works it: it takes the packet, reads and decodes the header, walks
// the options through WALK_A, WALK_B and WALK_C (one buffer read port, two
// words per option), chooses an insertion, updates the checksums through
// one shared adder (TCP only for a clamp, TCP and IP for an insertion),
// then emits one word per cycle and drains. Results pass p_valid_reg and
// strobe_reg after their emit states. A packet of more than 30 words
// gives a single registered beat after its last word is taken.
// Results appear for one cycle each under strobe; the receiver cannot
// stall them, so it must take every beat as it comes.

module tcp_mss_clamp_engine_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  tmc_pkg::in_t      item,
    output logic              strobe,
    output tmc_pkg::out_t     result,
    input  logic              cfg_write,
    input  tmc_pkg::cfg_idx_t cfg_index,
    input  logic [15:0]       cfg_data
);
    import tmc_pkg::*;

    cfg_t    cfg_reg, cfg_next;
    mem_wr_t wr;
    desc_t   desc;
    logic    desc_valid, desc_take, back_active;

    // configuration register file
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_CLAMP_MODE: cfg_next.clamp_mode      = cfg_data[0];
                CFG_FIXED_MSS:  cfg_next.fixed_mss       = cfg_data;
                CFG_ROUTE_MTU:  cfg_next.route_mtu       = cfg_data;
                CFG_SRC_MTU:    cfg_next.source_path_mtu = cfg_data;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.clamp_mode      <= 1'b0;
            cfg_reg.fixed_mss       <= 16'd1460;
            cfg_reg.route_mtu       <= 16'd1500;
            cfg_reg.source_path_mtu <= 16'd1500;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // word intake and descriptor queue
    tmc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .item        (item),
        .back_active (back_active),
        .desc_take   (desc_take),
        .busy        (busy),
        .wr          (wr),
        .desc        (desc),
        .desc_valid  (desc_valid)
    );

    // packet processing and emission
    tmc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr         (wr),
        .desc       (desc),
        .desc_valid (desc_valid),
        .cfg        (cfg_reg),
        .desc_take  (desc_take),
        .active     (back_active),
        .strobe     (strobe),
        .result     (result)
    );

endmodule

/* rtl/tmc_front.sv */
// front part: takes packet words, writes the packet buffer, counts words
// and hands a one-entry descriptor queue to the back part; uses tmc_pkg
`timescale 1ns / 1ps

module tmc_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  tmc_pkg::in_t    item,
    input  logic            back_active,
    input  logic            desc_take,
    output logic            busy,
    output tmc_pkg::mem_wr_t wr,
    output tmc_pkg::desc_t  desc,
    output logic            desc_valid
);
    import tmc_pkg::*;

    logic [CNT_W-1:0] count_reg, count_next, count_inc;
    logic             fwd_reg, fwd_next, rev_reg, rev_next;
    logic             first_beat, fwd_eff, rev_eff, accept;
    logic             desc_valid_reg, desc_valid_next;
    desc_t            desc_reg, desc_next;

    // handshake: hold off while a packet waits or is worked on
    assign busy   = desc_valid_reg | back_active;
    assign accept = start & ~busy;

    assign first_beat = (count_reg == '0);
    assign fwd_eff    = first_beat ? item.is_forward : fwd_reg;
    assign rev_eff    = first_beat ? item.is_reverse : rev_reg;
    assign count_inc  = (count_reg == CNT_MAX) ? count_reg : count_reg + 1'b1;

    // buffer write port
    always_comb
    begin
        wr.en   = accept && ({1'b0, count_reg} < (CNT_W + 1)'(BUFFER_WORDS));
        wr.addr = count_reg[ADDR_W-1:0];
        wr.data = item.packet_word;
    end

    // counter, direction flags and descriptor queue
    always_comb
    begin
        count_next      = count_reg;
        fwd_next        = fwd_reg;
        rev_next        = rev_reg;
        desc_valid_next = desc_valid_reg;
        desc_next       = desc_reg;
        if (desc_take)
        begin
            desc_valid_next = 1'b0;
        end
        if (accept)
        begin
            if (first_beat)
            begin
                fwd_next = item.is_forward;
                rev_next = item.is_reverse;
            end
            if (item.last_word)
            begin
                count_next      = '0;
                desc_valid_next = 1'b1;
                desc_next.n     = count_inc;
                desc_next.fwd   = fwd_eff;
                desc_next.rev   = rev_eff;
            end
            else
            begin
                count_next = count_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            fwd_reg        <= 1'b0;
            rev_reg        <= 1'b0;
            desc_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            fwd_reg        <= fwd_next;
            rev_reg        <= rev_next;
            desc_valid_reg <= desc_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        desc_reg <= desc_next;
    end

    assign desc       = desc_reg;
    assign desc_valid = desc_valid_reg;

endmodule

/* rtl/tmc_back.sv */
// back part: packet buffer memory, header checks, option walk, checksum
// updates and patched emission of the packet; uses tmc_pkg
`timescale 1ns / 1ps

module tmc_back (
    input  logic             clk,
    input  logic             rst_n,
    input  tmc_pkg::mem_wr_t wr,
    input  tmc_pkg::desc_t   desc,
    input  logic             desc_valid,
    input  tmc_pkg::cfg_t    cfg,
    output logic             desc_take,
    output logic             active,
    output logic             strobe,
    output tmc_pkg::out_t    result
);
    import tmc_pkg::*;

    localparam int POS_W = 7;
    localparam int I_W   = 9;
    localparam int NP    = 4;

    back_state_t state_reg, state_next;

    // packet buffer
    logic [31:0]       store_reg [BUFFER_WORDS];
    logic [31:0]       mem_q_reg;
    logic [CNT_W-1:0]  rd_idx;
    logic              rd_ok_reg;
    logic [31:0]       dq;

    // header fields and working values
    logic [N_W-1:0]    n_reg, n_next;
    logic              fwd_reg, fwd_next, rev_reg, rev_next;
    logic [3:0]        ihl_reg, ihl_next;
    logic [15:0]       tot_reg, tot_next;
    logic [7:0]        proto_reg, proto_next;
    logic [15:0]       ipck_reg, ipck_next;
    logic [15:0]       o12_reg, o12_next;
    logic [15:0]       tcpck_reg, tcpck_next;
    logic [15:0]       newmss_reg, newmss_next;
    logic [15:0]       oldmss_reg, oldmss_next;
    logic [31:0]       lo_word_reg, lo_word_next;
    logic [I_W-1:0]    i_reg, i_next;
    logic [2:0]        step_reg, step_next;
    logic              ins_reg, ins_next;
    status_t           status_reg, status_next;
    logic [N_W-1:0]    k_reg, k_next;

    // byte patches applied on emission
    logic [POS_W-1:0]  ppos_reg [NP];
    logic [POS_W-1:0]  ppos_next [NP];
    logic [15:0]       pval_reg [NP];
    logic [15:0]       pval_next [NP];
    logic [NP-1:0]     pen_reg, pen_next;

    // emission pipe and output beat
    logic              p_valid_reg, p_valid_next;
    logic [N_W-1:0]    p_k_reg, p_k_next;
    logic              p_slot_reg, p_slot_next;
    logic              p_last_reg, p_last_next;
    logic              strobe_reg, strobe_next;
    out_t              result_reg, result_next;

    // decode helpers
    logic [7:0]        flags;
    logic [3:0]        doff;
    logic [5:0]        th, dl;
    logic [6:0]        n4;
    logic              elig, bad_len, bad_mtu, too_long;
    logic [15:0]       mtu_min, newmss_c;
    logic [63:0]       win;
    logic [7:0]        opt_kind, opt_len;
    logic [15:0]       opt_mss;
    logic              opt_found;
    logic [I_W-1:0]    i_step;
    logic [N_W-1:0]    n_out, slot_idx, src_idx;
    logic              emit_slot, emit_last;
    logic [15:0]       ck_a, ck_f, ck_t, ck_r;
    logic [31:0]       emit_word;

    // memory: front writes, back reads one word a cycle
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            store_reg[wr.addr] <= wr.data;
        end
        mem_q_reg <= store_reg[rd_idx[ADDR_W-1:0]];
    end

    assign dq = rd_ok_reg ? mem_q_reg : 32'd0;

    // header decode
    assign flags    = o12_reg[7:0];
    assign doff     = o12_reg[15:12];
    assign th       = {ihl_reg, 2'b00};
    assign dl       = {doff, 2'b00};
    assign n4       = {n_reg, 2'b00};
    assign elig     = (proto_reg == PROTO_TCP) && flags[1] &&
                      (!flags[4] || (fwd_reg && rev_reg));
    assign bad_len  = ({1'b0, th} > n4) || ((n4 - {1'b0, th}) != {1'b0, dl}) ||
                      (doff < DOFF_MIN);
    assign bad_mtu  = cfg.clamp_mode &&
                      ((cfg.route_mtu <= HDR_MIN) || (cfg.source_path_mtu <= HDR_MIN));
    assign mtu_min  = (cfg.route_mtu < cfg.source_path_mtu) ? cfg.route_mtu
                                                            : cfg.source_path_mtu;
    assign newmss_c = cfg.clamp_mode ? mtu_min - HDR_MIN : cfg.fixed_mss;
    assign too_long = desc.n > CNT_W'(MAX_PKT_WORDS);

    // option window: two words, shifted to the current byte
    assign win       = {lo_word_reg, dq} << {i_reg[1:0], 3'b000};
    assign opt_kind  = win[63:56];
    assign opt_len   = win[55:48];
    assign opt_mss   = win[47:32];
    assign opt_found = (opt_kind == OPT_MSS) && (opt_len == OPT_MSS_LEN) &&
                       (({3'b000, dl} - i_reg) >= I_W'(4));
    assign i_step    = i_reg + (((opt_kind <= OPT_NOP) || (opt_len == 8'd0)) ?
                       I_W'(1) : {1'b0, opt_len});

    // emission indexing around the inserted word
    assign n_out     = n_reg + {{(N_W-1){1'b0}}, ins_reg};
    assign slot_idx  = {1'b0, ihl_reg} + N_W'(5);
    assign emit_slot = ins_reg && (k_reg == slot_idx);
    assign src_idx   = (ins_reg && (k_reg > slot_idx)) ? k_reg - 1'b1 : k_reg;
    assign emit_last = (k_reg == n_out - 1'b1);

    // read address per state
    always_comb
    begin
        case (state_reg)
            BK_RD_W0:    rd_idx = '0;
            BK_RD_W2:    rd_idx = CNT_W'(2);
            BK_RD_FLAGS: rd_idx = {2'b00, ihl_reg} + CNT_W'(3);
            BK_RD_CK:    rd_idx = {2'b00, ihl_reg} + CNT_W'(4);
            BK_WALK_A:   rd_idx = {2'b00, ihl_reg} + {2'b00, i_reg[5:2]};
            BK_WALK_B:   rd_idx = {2'b00, ihl_reg} + {2'b00, i_reg[5:2]} + 1'b1;
            BK_EMIT:     rd_idx = {1'b0, src_idx};
            default:     rd_idx = '0;
        endcase
    end

    // shared checksum update unit
    always_comb
    begin
        ck_a = tcpck_reg;
        ck_f = oldmss_reg;
        ck_t = newmss_reg;
        if (ins_reg)
        begin
            case (step_reg)
                3'd0:
                begin
                    ck_f = {10'd0, dl};
                    ck_t = {10'd0, dl} + 16'd4;
                end
                3'd1:
                begin
                    ck_f = 16'd0;
                    ck_t = MSS_KIND_LEN;
                end
                3'd2:
                begin
                    ck_f = 16'd0;
                    ck_t = newmss_reg;
                end
                3'd3:
                begin
                    ck_f = o12_reg;
                    ck_t = o12_reg + DOFF_INC;
                end
                default:
                begin
                    ck_a = ipck_reg;
                    ck_f = tot_reg;
                    ck_t = tot_reg + 16'd4;
                end
            endcase
        end
        ck_r = csum_fix(ck_a, ck_f, ck_t);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (desc_valid && !too_long)
                begin
                    state_next = BK_RD_W0;
                end
            end
            BK_RD_W0:    state_next = BK_RD_W2;
            BK_RD_W2:    state_next = BK_RD_FLAGS;
            BK_RD_FLAGS: state_next = BK_RD_CK;
            BK_RD_CK:    state_next = BK_DECIDE;
            BK_DECIDE:
            begin
                if (!elig || bad_len || bad_mtu)
                begin
                    state_next = BK_EMIT;
                end
                else if (dl > 6'd20)
                begin
                    state_next = BK_WALK_A;
                end
                else
                begin
                    state_next = BK_MISS;
                end
            end
            BK_WALK_A:   state_next = BK_WALK_B;
            BK_WALK_B:   state_next = BK_WALK_C;
            BK_WALK_C:
            begin
                if (opt_found)
                begin
                    state_next = (opt_mss > newmss_reg) ? BK_CKSUM : BK_EMIT;
                end
                else if (i_step < {3'b000, dl})
                begin
                    state_next = BK_WALK_A;
                end
                else
                begin
                    state_next = BK_MISS;
                end
            end
            BK_MISS:     state_next = (doff == DOFF_MAX) ? BK_EMIT : BK_CKSUM;
            BK_CKSUM:
            begin
                if (!ins_reg || (step_reg == 3'd4))
                begin
                    state_next = BK_EMIT;
                end
            end
            BK_EMIT:
            begin
                if (emit_last)
                begin
                    state_next = BK_FLUSH;
                end
            end
            BK_FLUSH:    state_next = BK_IDLE;
            default:     state_next = BK_IDLE;
        endcase
    end

    // patched output word
    always_comb
    begin
        logic [POS_W-1:0] pos;
        emit_word = p_slot_reg ? {MSS_KIND_LEN, newmss_reg} : mem_q_reg;
        for (int b = 0; b < 4; b++)
        begin
            pos = {p_k_reg, 2'(b)};
            for (int j = 0; j < NP; j++)
            begin
                if (pen_reg[j] && (pos == ppos_reg[j]))
                begin
                    emit_word[31 - 8 * b -: 8] = pval_reg[j][15:8];
                end
                if (pen_reg[j] && (pos == ppos_reg[j] + 1'b1))
                begin
                    emit_word[31 - 8 * b -: 8] = pval_reg[j][7:0];
                end
            end
        end
    end

    // datapath and outputs
    always_comb
    begin
        n_next       = n_reg;
        fwd_next     = fwd_reg;
        rev_next     = rev_reg;
        ihl_next     = ihl_reg;
        tot_next     = tot_reg;
        proto_next   = proto_reg;
        ipck_next    = ipck_reg;
        o12_next     = o12_reg;
        tcpck_next   = tcpck_reg;
        newmss_next  = newmss_reg;
        oldmss_next  = oldmss_reg;
        lo_word_next = lo_word_reg;
        i_next       = i_reg;
        step_next    = step_reg;
        ins_next     = ins_reg;
        status_next  = status_reg;
        k_next       = k_reg;
        ppos_next    = ppos_reg;
        pval_next    = pval_reg;
        pen_next     = pen_reg;
        p_valid_next = 1'b0;
        p_k_next     = k_reg;
        p_slot_next  = emit_slot;
        p_last_next  = emit_last;
        strobe_next  = 1'b0;
        result_next  = result_reg;
        desc_take    = 1'b0;

        case (state_reg)
            BK_IDLE:
            begin
                if (desc_valid)
                begin
                    desc_take = 1'b1;
                    if (too_long)
                    begin
                        strobe_next          = 1'b1;
                        result_next.out_word = 32'd0;
                        result_next.out_last = 1'b1;
                        result_next.status   = ST_TOO_LONG;
                    end
                    else
                    begin
                        n_next   = desc.n[N_W-1:0];
                        fwd_next = desc.fwd;
                        rev_next = desc.rev;
                        ins_next = 1'b0;
                        pen_next = '0;
                        k_next   = '0;
                    end
                end
            end
            BK_RD_W2:
            begin
                ihl_next = dq[27:24];
                tot_next = dq[15:0];
            end
            BK_RD_FLAGS:
            begin
                proto_next = dq[23:16];
                ipck_next  = dq[15:0];
            end
            BK_RD_CK:
            begin
                o12_next = dq[31:16];
            end
            BK_DECIDE:
            begin
                tcpck_next  = dq[31:16];
                newmss_next = newmss_c;
                i_next      = I_W'(20);
                if (!elig)
                begin
                    status_next = ST_NOT_ELIG;
                end
                else if (bad_len)
                begin
                    status_next = ST_BAD_LEN;
                end
                else if (bad_mtu)
                begin
                    status_next = ST_BAD_MTU;
                end
                else
                begin
                    status_next = ST_KEPT;
                end
            end
            BK_WALK_B:
            begin
                lo_word_next = dq;
            end
            BK_WALK_C:
            begin
                if (opt_found)
                begin
                    oldmss_next = opt_mss;
                    if (opt_mss > newmss_reg)
                    begin
                        status_next  = ST_CLAMPED;
                        ppos_next[0] = {1'b0, th} + i_reg[POS_W-1:0] + POS_W'(2);
                        pval_next[0] = newmss_reg;
                        ppos_next[1] = {1'b0, th} + POS_W'(16);
                        pen_next     = 4'b0011;
                    end
                end
                else
                begin
                    i_next = i_step;
                end
            end
            BK_MISS:
            begin
                if (doff == DOFF_MAX)
                begin
                    status_next = ST_NO_ROOM;
                end
                else
                begin
                    status_next  = ST_INSERTED;
                    ins_next     = 1'b1;
                    step_next    = '0;
                    ppos_next[0] = POS_W'(2);
                    pval_next[0] = tot_reg + 16'd4;
                    ppos_next[1] = POS_W'(10);
                    ppos_next[2] = {1'b0, th} + POS_W'(12);
                    pval_next[2] = o12_reg + DOFF_INC;
                    ppos_next[3] = {1'b0, th} + POS_W'(16);
                    pen_next     = 4'b1111;
                end
            end
            BK_CKSUM:
            begin
                if (!ins_reg)
                begin
                    pval_next[1] = ck_r;
                end
                else if (step_reg == 3'd4)
                begin
                    pval_next[1] = ck_r;
                    pval_next[3] = tcpck_reg;
                end
                else
                begin
                    tcpck_next = ck_r;
                    step_next  = step_reg + 1'b1;
                end
            end
            BK_EMIT:
            begin
                p_valid_next = 1'b1;
                k_next       = k_reg + 1'b1;
            end
            default:
            begin
            end
        endcase

        if (p_valid_reg)
        begin
            strobe_next          = 1'b1;
            result_next.out_word = emit_word;
            result_next.out_last = p_last_reg;
            result_next.status   = status_reg;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= BK_IDLE;
            p_valid_reg <= 1'b0;
            strobe_reg  <= 1'b0;
            pen_reg     <= '0;
            ins_reg     <= 1'b0;
            step_reg    <= '0;
            k_reg       <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            p_valid_reg <= p_valid_next;
            strobe_reg  <= strobe_next;
            pen_reg     <= pen_next;
            ins_reg     <= ins_next;
            step_reg    <= step_next;
            k_reg       <= k_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        rd_ok_reg   <= (rd_idx < {1'b0, n_reg});
        n_reg       <= n_next;
        fwd_reg     <= fwd_next;
        rev_reg     <= rev_next;
        ihl_reg     <= ihl_next;
        tot_reg     <= tot_next;
        proto_reg   <= proto_next;
        ipck_reg    <= ipck_next;
        o12_reg     <= o12_next;
        tcpck_reg   <= tcpck_next;
        newmss_reg  <= newmss_next;
        oldmss_reg  <= oldmss_next;
        lo_word_reg <= lo_word_next;
        i_reg       <= i_next;
        status_reg  <= status_next;
        ppos_reg    <= ppos_next;
        pval_reg    <= pval_next;
        p_k_reg     <= p_k_next;
        p_slot_reg  <= p_slot_next;
        p_last_reg  <= p_last_next;
        result_reg  <= result_next;
    end

    assign active = (state_reg != BK_IDLE);
    assign strobe = strobe_reg;
    assign result = result_reg;

endmodule
